/* src/acs_pkg.sv */
// acs_pkg: shared types and constants for the accumulator cpu step block
// instruction fields, operation codes and the execute result bundle
// no dependencies
`timescale 1ns / 1ps

package acs_pkg;

    // word memory size, a power of two so addresses wrap by truncation
    localparam int ACS_MEM_WORDS = 256;
    localparam int ACS_ADDR_W    = $clog2(ACS_MEM_WORDS);
    localparam int ACS_DATA_W    = 16;
    localparam int ACS_LEN_W     = 10;
    localparam int ACS_RIDX_W    = 3;
    localparam int ACS_REGS      = 8;

    localparam logic [ACS_RIDX_W-1:0] ACS_ACC_IDX = 3'd0;

    typedef enum logic [1:0] {
        OP_MOV = 2'b00,
        OP_BNZ = 2'b01,
        OP_ALU = 2'b10,
        OP_IMM = 2'b11
    } acs_op_t;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_AND = 3'd2,
        FN_NOR = 3'd3,
        FN_SHL = 3'd4,
        FN_SAR = 3'd5,
        FN_LW  = 3'd6,
        FN_SW  = 3'd7
    } acs_fn_t;

    typedef struct packed {
        acs_op_t               op;
        logic [ACS_RIDX_W-1:0] a;
        logic [ACS_RIDX_W-1:0] b;
    } acs_ins_t;

    typedef struct packed {
        logic [ACS_DATA_W-1:0] acc_next;
        logic [ACS_DATA_W-1:0] pc_next;
        logic                  rf_we;
        logic [ACS_RIDX_W-1:0] rf_waddr;
        logic [ACS_DATA_W-1:0] rf_wdata;
        logic                  mem_we;
        logic                  mem_rd;
        logic [ACS_ADDR_W-1:0] mem_addr;
    } acs_exec_t;

endpackage

/* src/acs_word_ram.sv */
// acs_word_ram: shared word memory, one write and one registered read port
// a read of the address written in the same cycle returns the new word
// depends on acs_pkg
`timescale 1ns / 1ps

module acs_word_ram
    import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [ACS_ADDR_W-1:0] waddr,
    input  logic [ACS_DATA_W-1:0] wdata,
    input  logic [ACS_ADDR_W-1:0] raddr,
    output logic [ACS_DATA_W-1:0] rdata
);

    logic [ACS_DATA_W-1:0] mem [ACS_MEM_WORDS];
    logic [ACS_DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/acs_reg_file.sv */
// acs_reg_file: general registers, two registered read ports, one write port
// entries read as zero until first written; the accumulator lives outside
// depends on acs_pkg
`timescale 1ns / 1ps

module acs_reg_file
    import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ACS_RIDX_W-1:0] rd_addr_a,
    input  logic [ACS_RIDX_W-1:0] rd_addr_b,
    output logic [ACS_DATA_W-1:0] rd_data_a,
    output logic [ACS_DATA_W-1:0] rd_data_b,
    input  logic                  wr_en,
    input  logic [ACS_RIDX_W-1:0] wr_addr,
    input  logic [ACS_DATA_W-1:0] wr_data
);

    logic [ACS_DATA_W-1:0] mem [ACS_REGS];
    logic [ACS_REGS-1:0]   valid_reg;
    logic [ACS_DATA_W-1:0] rd_a_reg;
    logic [ACS_DATA_W-1:0] rd_b_reg;
    logic                  va_reg;
    logic                  vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            va_reg <= valid_reg[rd_addr_a];
            vb_reg <= valid_reg[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = va_reg ? rd_a_reg : '0;
    assign rd_data_b = vb_reg ? rd_b_reg : '0;

endmodule

/* src/acs_alu.sv */
// acs_alu: executes one decoded instruction on the operand values
// gives next pc, next accumulator and the register and memory requests
// depends on acs_pkg
`timescale 1ns / 1ps

module acs_alu
    import acs_pkg::*;
(
    input  acs_ins_t              ins,
    input  logic [ACS_DATA_W-1:0] pc,
    input  logic [ACS_DATA_W-1:0] acc,
    input  logic [ACS_DATA_W-1:0] ra,
    input  logic [ACS_DATA_W-1:0] rb,
    output acs_exec_t             res
);

    acs_fn_t fn;

    assign fn = acs_fn_t'(ins.a);

    always_comb
    begin
        res          = '0;
        res.acc_next = acc;
        res.pc_next  = pc + 16'd1;
        res.rf_waddr = ins.a;
        res.rf_wdata = rb;
        res.mem_addr = ACS_ADDR_W'(rb);
        case (ins.op)
            OP_MOV:
            begin
                if (ins.a == ACS_ACC_IDX)
                begin
                    res.acc_next = rb;
                end
                else
                begin
                    res.rf_we = 1'b1;
                end
            end
            OP_BNZ:
            begin
                if (rb != '0)
                begin
                    res.pc_next = ra;
                end
            end
            OP_ALU:
            begin
                case (fn)
                    FN_ADD:  res.acc_next = acc + rb;
                    FN_SUB:  res.acc_next = acc - rb;
                    FN_AND:  res.acc_next = acc & rb;
                    FN_NOR:  res.acc_next = ~(acc | rb);
                    FN_SHL:  res.acc_next = acc << ins.b;
                    FN_SAR:  res.acc_next = ACS_DATA_W'($signed(acc) >>> ins.b);
                    FN_LW:   res.mem_rd   = 1'b1;
                    FN_SW:   res.mem_we   = 1'b1;
                    default: res.acc_next = acc;
                endcase
            end
            OP_IMM:
            begin
                res.acc_next = {{(ACS_DATA_W - 6){1'b0}}, ins.a, ins.b};
            end
            default:
            begin
                res.acc_next = acc;
            end
        endcase
    end

endmodule

/* src/accumulator_cpu_step.sv */
// accumulator_cpu_step: top level, sequencer around word memory and registers
// depends on acs_pkg, acs_word_ram, acs_reg_file, acs_alu
`timescale 1ns / 1ps

// Usage
// s_* carries requests: s_tuser[0] is the mode (0 load a word, 1 step one
// instruction), s_tdata holds load_address and load_data. m_* returns one
// result per request: program counter, accumulator and the finished flag.
// cfg_we / cfg_wdata write the program length while the block is idle.
// A load or a step past the program end completes in the ready state; an
// executed step reads its register operands as it is taken and executes in
// the execute state, and a memory load instruction then takes its data in
// the load state. The word memory has a single read port, which the execute
// state uses for the next fetch or for a memory load's data read. The next
// instruction word is fetched ahead, so a request can be taken in the cycle
// after the previous one completes. The result sits in an output register
// and shows in the cycle after the request completes. While it is held by a
// stalled receiver, s_tready stays low unless m_tready takes the result in
// the same cycle. After reset the word memory is cleared one word a cycle;
// s_tready is low during that pass, configuration writes are taken.
module accumulator_cpu_step
    import acs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // load_address[7:0], load_data[23:8]
    input  logic [0:0]           s_tuser,   // mode[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // program_counter[15:0], accumulator[31:16]
    output logic [0:0]           m_tuser,   // finished[0]
    input  logic                 cfg_we,
    input  logic [ACS_LEN_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READY,
        ST_EXEC,
        ST_LW
    } state_t;

    state_t                state_reg, state_next;
    logic [ACS_ADDR_W-1:0] clr_reg, clr_next;
    logic [ACS_DATA_W-1:0] pc_reg, pc_next;
    logic [ACS_DATA_W-1:0] acc_reg, acc_next;
    acs_ins_t              ins_reg, ins_next;
    logic [ACS_LEN_W-1:0]  len_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [ACS_DATA_W-1:0] out_pc_reg, out_pc_next;
    logic [ACS_DATA_W-1:0] out_acc_reg, out_acc_next;
    logic                  out_fin_reg, out_fin_next;

    logic                  s_accept;
    logic                  m_take;
    logic                  mode;
    logic [7:0]            ld_addr;
    logic [ACS_DATA_W-1:0] ld_data;
    logic                  fin_now;
    logic                  fin_exec;

    logic                  ram_we;
    logic [ACS_ADDR_W-1:0] ram_waddr;
    logic [ACS_DATA_W-1:0] ram_wdata;
    logic [ACS_ADDR_W-1:0] ram_raddr;
    logic [ACS_DATA_W-1:0] ram_rdata;

    logic [7:0]            ins_byte;
    acs_ins_t              fetch_ins;
    logic [ACS_DATA_W-1:0] rf_rd_a;
    logic [ACS_DATA_W-1:0] rf_rd_b;
    logic [ACS_DATA_W-1:0] op_a;
    logic [ACS_DATA_W-1:0] op_b;
    logic                  rf_we;
    acs_exec_t             exec;

    assign mode    = s_tuser[0];
    assign ld_addr = s_tdata[7:0];
    assign ld_data = s_tdata[23:8];

    assign m_take   = out_valid_reg && m_tready;
    assign s_tready = (state_reg == ST_READY) && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign fin_now  = pc_reg >= {{(ACS_DATA_W - ACS_LEN_W){1'b0}}, len_reg};
    assign fin_exec = exec.pc_next >= {{(ACS_DATA_W - ACS_LEN_W){1'b0}}, len_reg};

    // high byte at even pc, low byte at odd pc
    assign ins_byte  = pc_reg[0] ? ram_rdata[7:0] : ram_rdata[15:8];
    assign fetch_ins = acs_ins_t'(ins_byte);

    // register 0 is the accumulator, held in its own flop
    assign op_a = (ins_reg.a == ACS_ACC_IDX) ? acc_reg : rf_rd_a;
    assign op_b = (ins_reg.b == ACS_ACC_IDX) ? acc_reg : rf_rd_b;

    assign rf_we = (state_reg == ST_EXEC) && exec.rf_we;

    acs_word_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    acs_reg_file u_rf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr_a (fetch_ins.a),
        .rd_addr_b (fetch_ins.b),
        .rd_data_a (rf_rd_a),
        .rd_data_b (rf_rd_b),
        .wr_en     (rf_we),
        .wr_addr   (exec.rf_waddr),
        .wr_data   (exec.rf_wdata)
    );

    acs_alu u_alu (
        .ins (ins_reg),
        .pc  (pc_reg),
        .acc (acc_reg),
        .ra  (op_a),
        .rb  (op_b),
        .res (exec)
    );

    // memory port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ACS_ADDR_W'(ld_addr);
        ram_wdata = ld_data;
        ram_raddr = ACS_ADDR_W'(pc_reg >> 1);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_READY:
            begin
                // keep re-reading the fetch word so loads to it are seen
                ram_we = s_accept && !mode;
            end
            ST_EXEC:
            begin
                ram_we    = exec.mem_we;
                ram_waddr = exec.mem_addr;
                ram_wdata = acc_reg;
                if (exec.mem_rd)
                begin
                    ram_raddr = exec.mem_addr;
                end
                else
                begin
                    ram_raddr = ACS_ADDR_W'(exec.pc_next >> 1);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pc_next        = pc_reg;
        acc_next       = acc_reg;
        ins_next       = ins_reg;
        out_valid_next = out_valid_reg && !m_take;
        out_pc_next    = out_pc_reg;
        out_acc_next   = out_acc_reg;
        out_fin_next   = out_fin_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ACS_ADDR_W'(ACS_MEM_WORDS - 1))
                begin
                    state_next = ST_READY;
                end
            end
            ST_READY:
            begin
                if (s_accept)
                begin
                    if (!mode || fin_now)
                    begin
                        out_valid_next = 1'b1;
                        out_pc_next    = pc_reg;
                        out_acc_next   = acc_reg;
                        out_fin_next   = fin_now;
                    end
                    else
                    begin
                        ins_next   = fetch_ins;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                pc_next  = exec.pc_next;
                acc_next = exec.acc_next;
                if (exec.mem_rd)
                begin
                    state_next = ST_LW;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_pc_next    = exec.pc_next;
                    out_acc_next   = exec.acc_next;
                    out_fin_next   = fin_exec;
                    state_next     = ST_READY;
                end
            end
            ST_LW:
            begin
                acc_next       = ram_rdata;
                out_valid_next = 1'b1;
                out_pc_next    = pc_reg;
                out_acc_next   = ram_rdata;
                out_fin_next   = fin_now;
                state_next     = ST_READY;
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= '0;
            acc_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg     <= ins_next;
        out_pc_reg  <= out_pc_next;
        out_acc_reg <= out_acc_next;
        out_fin_reg <= out_fin_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_acc_reg, out_pc_reg};
    assign m_tuser  = out_fin_reg;

endmodule

/* src/acs_checker.sv */
// acs_checker: port-level checks for accumulator_cpu_step, bound to the top
// depends on acs_pkg and the top level's ports
`timescale 1ns / 1ps

module acs_checker
    import acs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [23:0]          s_tdata,   // load_address[7:0], load_data[23:8]
    input logic [0:0]           s_tuser,   // mode[0]
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [31:0]          m_tdata,   // program_counter[15:0], accumulator[31:16]
    input logic [0:0]           m_tuser,   // finished[0]
    input logic                 cfg_we,
    input logic [ACS_LEN_W-1:0] cfg_wdata
);

    logic [ACS_LEN_W-1:0] len_reg;
    logic [1:0]           pend_reg;
    logic                 s_acc;
    logic                 m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            pend_reg <= pend_reg + {1'b0, s_acc} - {1'b0, m_acc};
        end
    end

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // finished flag matches the reported pc against the program length
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] ==
            (m_tdata[15:0] >= {{(ACS_DATA_W - ACS_LEN_W){1'b0}}, len_reg})))
        else $error("finished flag inconsistent with pc");

    // no result without a request behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_acc |-> pend_reg != 2'd0)
        else $error("result without request");

    // at most one request in flight
    a_one_pend: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |-> (pend_reg == 2'd0) || (pend_reg == 2'd1 && m_acc))
        else $error("request taken while another is in flight");

endmodule

bind accumulator_cpu_step acs_checker u_acs_checker (.*);
